// File: design/assert_macros.svh
// assertion helpers included by hbd_window
// both expect i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define HBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_pkg
// shared constants and types of the half-band decimator by two
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int TAP_COUNT  = 11;
    localparam int EVEN_COEFS = 6;
    localparam int CENTER_POS = (TAP_COUNT - 1) / 2;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 15;
    localparam int FILL_W   = $clog2(TAP_COUNT + 1);

    // products over even positions, then the centre product
    localparam int NUM_EVEN = ((TAP_COUNT + 1) / 2 < EVEN_COEFS) ?
                              (TAP_COUNT + 1) / 2 : EVEN_COEFS;
    localparam int NUM_PROD = NUM_EVEN + 1;
    localparam int NUM_PAIR = (NUM_PROD + 1) / 2;

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PAIR_W + $clog2(NUM_PAIR) + 1;
    localparam int Q_W    = ACC_W - FRAC_W;

    // register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER = CFG_IDX_W'(EVEN_COEFS);

    localparam logic [SAMPLE_W-1:0] COEF_EVEN_RST   = '0;
    localparam logic [SAMPLE_W-1:0] COEF_CENTER_RST = SAMPLE_W'(16384);

    // round half up before the floor shift
    localparam logic signed [PAIR_W-1:0] ROUND_ADD = PAIR_W'(1) << (FRAC_W - 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [TAP_COUNT-1:0]    t_window;

    typedef struct packed {
        t_sample [EVEN_COEFS-1:0] even;
        t_sample                  center;
    } t_coefs;

endpackage

`default_nettype wire

// File: design/hbd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_in_if
// input sample channel, valid/ready
// ----------------------------------------------------------------------------
interface hbd_in_if;
    import hbd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);

endinterface

`default_nettype wire

// File: design/hbd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_out_if
// decimated output channel, valid/ready
// ----------------------------------------------------------------------------
interface hbd_out_if;
    import hbd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);

endinterface

`default_nettype wire

// File: design/hbd_coef_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_coef_regs
// coefficient register file, write only
// ----------------------------------------------------------------------------
module hbd_coef_regs (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [hbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [hbd_pkg::SAMPLE_W-1:0]    i_cfg_data,
    output hbd_pkg::t_coefs                 o_coefs
);
    import hbd_pkg::*;

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EVEN_COEFS; k++) begin
                r_coefs.even[k] <= COEF_EVEN_RST;
            end
            r_coefs.center <= COEF_CENTER_RST;
        end else if (i_cfg_we) begin
            for (int k = 0; k < EVEN_COEFS; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_coefs.even[k] <= i_cfg_data;
                end
            end
            // indexes past the centre are dropped
            if (i_cfg_idx == CFG_IDX_CENTER) begin
                r_coefs.center <= i_cfg_data;
            end
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// File: design/hbd_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_window
// sample delay line with fill count and decimation phase
// ----------------------------------------------------------------------------
module hbd_window (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire  [hbd_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_ready,
    input  wire                          i_next_ready,
    output logic                         o_vld,
    output hbd_pkg::t_window             o_win
);
    import hbd_pkg::*;

    `include "assert_macros.svh"

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAP_COUNT);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(TAP_COUNT - 1);

    t_window           r_win;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_phase;
    logic              n_phase;
    logic              r_vld;
    logic              n_vld;
    logic              accept;
    logic              full_next;

    // window may only move once its snapshot has left for the multipliers
    assign o_ready = !r_vld || i_next_ready;
    assign accept  = i_valid && o_ready;

    assign full_next = (r_fill == FILL_LAST) || (r_fill == FILL_FULL);

    always_comb begin
        n_fill  = r_fill;
        n_phase = r_phase;
        n_vld   = r_vld;
        if (accept) begin
            if (r_fill != FILL_FULL) begin
                n_fill = r_fill + FILL_W'(1);
            end
            n_vld = full_next && !r_phase;
            if (full_next) begin
                n_phase = !r_phase;
            end
        end else if (i_next_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_phase <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_phase <= n_phase;
            r_vld   <= n_vld;
        end
    end

    // position 0 oldest, top position newest
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < TAP_COUNT - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[TAP_COUNT - 1] <= i_sample;
        end
    end

    assign o_vld = r_vld;
    assign o_win = r_win;

    `HBD_ASSERT(a_fill_bound, r_fill <= FILL_FULL, "fill count past tap count")
    `HBD_ASSERT(a_phase_unfilled, (r_fill == FILL_FULL) || !r_phase,
        "phase moved before line full")
    `HBD_ASSERT(a_emit_full, !r_vld || (r_fill == FILL_FULL),
        "result launched from partial line")
    `HBD_ASSERT_NEXT(a_win_hold, r_vld && !i_next_ready, $stable(r_win),
        "window moved under stalled snapshot")

endmodule

`default_nettype wire

// File: design/hbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_datapath
// products, pair sums, rounding and saturation, output register
// ----------------------------------------------------------------------------
module hbd_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_vld,
    output logic                         o_ready,
    input  hbd_pkg::t_window             i_win,
    input  hbd_pkg::t_coefs              i_coefs,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [hbd_pkg::SAMPLE_W-1:0] o_sample
);
    import hbd_pkg::*;

    logic signed [PROD_W-1:0] n_prod [NUM_PROD];
    logic signed [PROD_W-1:0] r_prod [NUM_PROD];
    logic signed [PAIR_W-1:0] n_pair [NUM_PAIR];
    logic signed [PAIR_W-1:0] r_pair [NUM_PAIR];
    logic signed [ACC_W-1:0]  acc;
    logic signed [Q_W-1:0]    q;
    logic [SAMPLE_W-1:0]      n_out;
    logic [SAMPLE_W-1:0]      r_out;
    logic                     r_prod_vld;
    logic                     r_pair_vld;
    logic                     r_out_vld;
    logic                     prod_ready;
    logic                     pair_ready;
    logic                     out_ready;

    // each stage moves when the one after it is empty or moving
    assign out_ready  = !r_out_vld || i_ready;
    assign pair_ready = !r_pair_vld || out_ready;
    assign prod_ready = !r_prod_vld || pair_ready;
    assign o_ready    = prod_ready;

    for (genvar e = 0; e < NUM_EVEN; e++) begin : g_even
        assign n_prod[e] = $signed(i_coefs.even[e]) * $signed(i_win[2 * e]);
    end
    assign n_prod[NUM_EVEN] = $signed(i_coefs.center) * $signed(i_win[CENTER_POS]);

    for (genvar j = 0; j < NUM_PAIR; j++) begin : g_pair
        logic signed [PAIR_W-1:0] hi;
        logic signed [PAIR_W-1:0] rnd;
        if (2 * j + 1 < NUM_PROD) begin : g_two
            assign hi = PAIR_W'(r_prod[2 * j + 1]);
        end else begin : g_one
            assign hi = '0;
        end
        if (j == 0) begin : g_rnd
            assign rnd = ROUND_ADD;
        end else begin : g_nornd
            assign rnd = '0;
        end
        assign n_pair[j] = PAIR_W'(r_prod[2 * j]) + hi + rnd;
    end

    always_comb begin
        acc = '0;
        for (int j = 0; j < NUM_PAIR; j++) begin
            acc = acc + ACC_W'(r_pair[j]);
        end
    end

    // floor shift, then clamp to the sample range
    assign q = Q_W'(acc >>> FRAC_W);

    always_comb begin
        if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
            n_out = q[SAMPLE_W-1:0];
        end else if (q[Q_W-1]) begin
            n_out = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            n_out = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_pair_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (prod_ready) begin
                r_prod_vld <= i_vld;
            end
            if (pair_ready) begin
                r_pair_vld <= r_prod_vld;
            end
            if (out_ready) begin
                r_out_vld <= r_pair_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_ready && i_vld) begin
            r_prod <= n_prod;
        end
        if (pair_ready && r_prod_vld) begin
            r_pair <= n_pair;
        end
        if (out_ready && r_pair_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_sample = r_out;

endmodule

`default_nettype wire

// File: design/halfband_decimator_by_two.sv
`timescale 1ns / 1ps
`default_nettype none
// a result passes the window, product, pair-sum and output registers in order
// throughput: one input beat per cycle unless held, one output per two once full
// the first output comes with the beat that fills the 11-sample line
// reset (sync, active low) clears fill count, phase and stage valids, and sets
// the even taps to zero and the center tap to one half
// the multiplier stage forms seven 16x16 products in parallel
// ----------------------------------------------------------------------------
// halfband_decimator_by_two
// streaming half-band fir decimator by two, q1.15 in and out
// ----------------------------------------------------------------------------
module halfband_decimator_by_two (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    hbd_in_if.sink                        i_in,
    hbd_out_if.source                     o_out,
    input  wire                           i_cfg_we,
    input  wire  [hbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [hbd_pkg::SAMPLE_W-1:0]  i_cfg_data
);
    import hbd_pkg::*;

    // user must write coefficients only while the pipe is drained; not enforced
    t_coefs  coefs;
    // snapshot of the delay line after the beat that launches a result
    t_window win;
    logic    win_vld;
    logic    dp_ready;

    hbd_coef_regs u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (coefs)
    );

    // delay line: shifts on every accepted beat, flags every second beat
    // once full; it holds still while its flagged snapshot waits for the
    // multiplier stage so the products see the right window
    hbd_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_sample     (i_in.in_sample),
        .o_ready      (i_in.ready),
        .i_next_ready (dp_ready),
        .o_vld        (win_vld),
        .o_win        (win)
    );

    // three register stages: products, pair sums with the rounding offset,
    // then final sum, floor shift and saturation into the output register;
    // each stage has its own valid so input stalls only once every stage is full
    hbd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (win_vld),
        .o_ready  (dp_ready),
        .i_win    (win),
        .i_coefs  (coefs),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_sample (o_out.out_sample)
    );

endmodule

`default_nettype wire

// File: tb/sv/halfband_decimator_by_two_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfband_decimator_by_two_checker
// watches the sample channels and the coefficient port, predicts every
// decimated sample and compares it with what the block delivers
// ----------------------------------------------------------------------------
module halfband_decimator_by_two_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            i_in_ready,
    input  hbd_pkg::t_sample               i_in_sample,
    input  wire                            i_out_valid,
    input  wire                            i_out_ready,
    input  hbd_pkg::t_sample               i_out_sample,
    input  wire                            i_cfg_we,
    input  wire  [hbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [hbd_pkg::SAMPLE_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import hbd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    t_window           delay_line;
    logic [FILL_W-1:0] samples_held;
    bit                odd_phase;
    t_coefs            coefs;
    t_sample           expected_samples[$];
    int                fail_count = 0;

    // exact sum of products, round half up, saturate to q1.15
    function automatic t_sample decimated_sample(input t_window w, input t_coefs c);
        longint acc;
        longint q;
        acc = 0;
        for (int j = 0; j < EVEN_COEFS; j++) begin
            if (2 * j < TAP_COUNT) begin
                acc += longint'(c.even[j]) * longint'(w[2 * j]);
            end
        end
        acc += longint'(c.center) * longint'(w[CENTER_POS]);
        q = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return t_sample'(q);
    endfunction

    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            delay_line   = '0;
            samples_held = '0;
            odd_phase    = 1'b0;
            for (int j = 0; j < EVEN_COEFS; j++) begin
                coefs.even[j] = COEF_EVEN_RST;
            end
            coefs.center = COEF_CENTER_RST;
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_IDX_W'(EVEN_COEFS)) begin
                    coefs.even[i_cfg_idx] = i_cfg_data;
                end else if (i_cfg_idx == CFG_IDX_CENTER) begin
                    coefs.center = i_cfg_data;
                end
            end

            // newest sample enters at the top, oldest drops out of position 0
            if (i_in_valid && i_in_ready) begin
                for (int k = 0; k < TAP_COUNT - 1; k++) begin
                    delay_line[k] = delay_line[k + 1];
                end
                delay_line[TAP_COUNT - 1] = i_in_sample;
                if (samples_held < TAP_COUNT) begin
                    samples_held++;
                end
                if (samples_held == TAP_COUNT) begin
                    if (!odd_phase) begin
                        expected_samples.push_back(decimated_sample(delay_line, coefs));
                    end
                    odd_phase = !odd_phase;
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected output beat: got %0d", i_out_sample);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out_sample !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("out_sample mismatch: expected %0d got %0d",
                                     want, i_out_sample);
                        end
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = expected_samples.size();
    end

endmodule

// File: tb/sv/halfband_decimator_by_two_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfband_decimator_by_two_tb
// drives the half-band decimator with directed edge samples and randomized
// streams under several coefficient sets, with random idling on both sides
// ----------------------------------------------------------------------------
module halfband_decimator_by_two_tb;
    import hbd_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 19;
    // leave some margin after the last output
    localparam int DRAIN_SLACK    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 128;
    localparam int PRESSURE_PHASE = 1;
    localparam int RUN_LENGTH     = 32;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int EDGE_COUNT     = 11;
    localparam int SAT_RUN        = 7;

    // index past the end of the register map, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

    localparam t_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    // extremes, sign edges and alternating bit patterns while the line fills
    localparam t_sample EDGE_SAMPLES [EDGE_COUNT] = '{
        32767, -32768, 0, -1, 1, 21845, -21846, 32767, -32768, 32767, -32768
    };

    typedef enum int {
        COEF_RANDOM,
        COEF_SMALL,
        COEF_ALL_MAX,
        COEF_ALL_MIN,
        COEF_CENTER_ONLY,
        COEF_ALTERNATE
    } t_coef_set;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SAMPLE_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int hold_requests = 0;
    int hold_served   = 0;

    hbd_in_if  in_ch ();
    hbd_out_if out_ch ();

    always #(CLK_HALF) i_clk = ~i_clk;

    halfband_decimator_by_two DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    halfband_decimator_by_two_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_sample  (in_ch.in_sample),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_sample (out_ch.out_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("halfband_decimator_by_two regression: fail");
            $finish;
        end
    end

    // wait before a beat; a run of zeros gives back-to-back stretches
    function automatic int draw_gap(input bit back_to_back);
        return back_to_back ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // mostly full-range samples, some rails and zero, some low-level signal
    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return t_sample'($urandom);
            5, 6: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return t_sample'(0);
                    default: return t_sample'(-1);
                endcase
            end
            default: return t_sample'(int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    function automatic t_coefs pick_coefs(input t_coef_set coef_set);
        t_coefs c;
        for (int j = 0; j < EVEN_COEFS; j++) begin
            case (coef_set)
                COEF_RANDOM:      c.even[j] = t_sample'($urandom);
                COEF_SMALL:       c.even[j] = t_sample'(int'($urandom_range(0, 8191)) - 4096);
                COEF_ALL_MAX:     c.even[j] = SAMPLE_MAX;
                COEF_ALL_MIN:     c.even[j] = SAMPLE_MIN;
                COEF_CENTER_ONLY: c.even[j] = '0;
                default:          c.even[j] = (j % 2) ? SAMPLE_MAX : SAMPLE_MIN;
            endcase
        end
        case (coef_set)
            COEF_RANDOM:      c.center = t_sample'($urandom);
            COEF_SMALL:       c.center = t_sample'(16384 + int'($urandom_range(0, 4095)) - 2048);
            COEF_ALL_MAX:     c.center = SAMPLE_MAX;
            COEF_ALL_MIN:     c.center = SAMPLE_MIN;
            COEF_CENTER_ONLY: c.center = t_sample'($urandom);
            default:          c.center = SAMPLE_MIN;
        endcase
        return c;
    endfunction

    // one input beat; valid stays high across back-to-back beats
    task automatic send_sample(input t_sample s, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_sample <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // all six even taps and the centre, then a write past the map
    task automatic program_coefs(input t_coefs c);
        for (int j = 0; j < EVEN_COEFS; j++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(j);
            i_cfg_data <= c.even[j];
            @(posedge i_clk);
        end
        i_cfg_idx  <= CFG_IDX_CENTER;
        i_cfg_data <= c.center;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_SPARE;
        i_cfg_data <= SAMPLE_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // sender pauses until every predicted sample is out, then lets the
    // pipeline settle so a trailing non-emitting beat is done too
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // output side: random stalls per beat, plus one long hold-off on request
    initial begin
        int stall;
        int beats;
        bit back_to_back;
        out_ch.ready <= 1'b0;
        beats        = 0;
        back_to_back = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_served < hold_requests) begin
                hold_served++;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (beats % RUN_LENGTH == 0) begin
                back_to_back = ($urandom_range(0, 3) == 0);
            end
            stall = draw_gap(back_to_back);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            beats++;
        end
    end

    // stimulus and verdict
    initial begin
        bit back_to_back;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.in_sample <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients (centre only, one half): edge samples fill the
        // line, nothing comes out until the eleventh, rounding of odd values
        for (int k = 0; k < EDGE_COUNT; k++) begin
            send_sample(EDGE_SAMPLES[k], draw_gap(1'b0));
        end
        wait_idle();

        // all taps at the negative rail: positive rail input saturates low,
        // then negative rail input saturates high
        program_coefs(pick_coefs(COEF_ALL_MIN));
        repeat (SAT_RUN) send_sample(SAMPLE_MAX, draw_gap(1'b0));
        repeat (SAT_RUN) send_sample(SAMPLE_MIN, draw_gap(1'b0));
        wait_idle();

        // random streams, a new coefficient set per phase while idle
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_coefs(pick_coefs(t_coef_set'(p % 6)));
            // output side blocks for a long stretch while input keeps coming
            if (p == PRESSURE_PHASE) begin
                hold_requests++;
            end
            back_to_back = 1'b0;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (k % RUN_LENGTH == 0) begin
                    back_to_back = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
                end
                send_sample(random_sample(), draw_gap(back_to_back));
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("halfband_decimator_by_two regression: pass");
        end else begin
            $display("halfband_decimator_by_two regression: fail");
        end
        $finish;
    end

endmodule
